[rtl/fbc_pkg.sv]
// fbc_pkg: shared constants, codes and word types of the feistel block cipher
// used by every module of the block; depends on nothing

package fbc_pkg;

    localparam int MAX_ROUNDS     = 16;
    localparam int KEY_ROTATE_MOD = 64;

    localparam int KEY_W     = 64;
    localparam int HALF_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int RCNT_W    = 5;
    localparam int CFG_IDX_W = 2;
    // effective round count and round index width
    localparam int NEFF_W    = ($clog2(MAX_ROUNDS + 1) > RCNT_W) ?
                               $clog2(MAX_ROUNDS + 1) : RCNT_W;
    localparam int ROT_W     = $clog2(KEY_ROTATE_MOD);

    typedef enum logic [1:0] {
        CMD_BLOCK = 2'd0,
        CMD_PAIR  = 2'd1,
        CMD_BYTE  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY    = 2'd0,
        REG_ROUNDS = 2'd1,
        REG_DIR    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [HALF_W-1:0] left_half;
        logic [HALF_W-1:0] right_half;
    } req_t;

    typedef struct packed {
        logic [HALF_W-1:0] out_left;
        logic [HALF_W-1:0] out_right;
    } rsp_t;

    // word as it travels down the cell row
    typedef struct packed {
        logic              active;
        logic              pair;
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } item_t;

    // per-cell round control; the user must keep it static while words are in flight, the block does not enforce it
    typedef struct packed {
        logic              live;
        logic              decrypt;
        logic [HALF_W-1:0] rkey;
    } ctl_t;

endpackage

[rtl/fbc_cell.sv]
// fbc_cell: one feistel round stage of the cell row, with its word register
// depends on fbc_pkg

module fbc_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  fbc_pkg::ctl_t ctl,
    input  logic          up_valid,
    input  fbc_pkg::item_t up_item,
    output logic          up_hold,
    output logic          dn_valid,
    output fbc_pkg::item_t dn_item,
    input  logic          dn_hold
);

    logic           valid_reg;
    logic           valid_next;
    fbc_pkg::item_t item_reg;
    fbc_pkg::item_t item_next;
    logic [fbc_pkg::HALF_W-1:0] src;
    logic [fbc_pkg::HALF_W-1:0] mix;
    logic [fbc_pkg::HALF_W-1:0] m;
    logic           load;

    assign up_hold    = valid_reg && dn_hold;
    assign load       = up_valid && !up_hold;
    assign valid_next = up_hold ? valid_reg : up_valid;

    always_comb
    begin
        src = ctl.decrypt ? up_item.right : up_item.left;
        m   = src ^ ctl.rkey;
        if (up_item.pair)
        begin
            mix = {{(fbc_pkg::HALF_W-fbc_pkg::BYTE_W){1'b0}},
                   src[7:0] ^ ctl.rkey[7:0] ^ ctl.rkey[31:24]};
        end
        else
        begin
            mix = {m[23:16] ^ m[31:24], m[15:8] ^ m[31:24],
                   m[23:16] ^ m[31:24], m[7:0] ^ m[31:24]};
        end
        item_next = up_item;
        if (up_item.active && ctl.live)
        begin
            if (ctl.decrypt)
            begin
                item_next.left  = up_item.right;
                item_next.right = up_item.left ^ mix;
            end
            else
            begin
                item_next.left  = up_item.right ^ mix;
                item_next.right = up_item.left;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

[rtl/feistel_block_cipher_top.sv]
// feistel_block_cipher_top: configuration registers, word entry and the row of round cells
// depends on fbc_pkg and fbc_cell
//
// Usage:
//   req channel (req_valid, req_stall, req_data) takes one cipher unit per word:
//   an eight-byte block, a byte pair or a lone leading byte, chosen by command.
//   rsp channel (rsp_valid, rsp_stall, rsp_data) returns exactly one word per unit,
//   in order. cfg channel writes key, round count and direction; cfg_ready is always
//   high. The user must write only while no word is in flight; the block does not enforce it.
// Path: every word passes the full row of MAX_ROUNDS cells (16), each a register
//   stage, before its result shows on rsp; cells past the round count and
//   lone bytes just pass through.
// Throughput: one word per cycle while req_stall is low; the row is one cell per round,
//   each cell a register stage.
// Stall: a stalled rsp word holds; cells behind it keep filling, and req_stall
//   rises only when every cell holds a word and the result is still stalled.
// Reset: clears all cell valids; key 0, round count 16, direction encrypt.

module feistel_block_cipher_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  fbc_pkg::req_t                     req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output fbc_pkg::rsp_t                     rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbc_pkg::KEY_W-1:0]         cfg_data
);

    localparam int N = fbc_pkg::MAX_ROUNDS;

    logic [fbc_pkg::KEY_W-1:0]  key_reg;
    logic [fbc_pkg::RCNT_W-1:0] rounds_reg;
    logic                       dir_reg;
    logic [fbc_pkg::NEFF_W-1:0] n_eff;
    logic [fbc_pkg::BYTE_W-1:0] byte_key;

    logic           valid_c [0:N];
    fbc_pkg::item_t item_c  [0:N];
    logic           hold_c  [0:N];
    fbc_pkg::ctl_t  ctl_c   [0:N-1];

    function automatic logic [fbc_pkg::HALF_W-1:0] round_key(
        input logic [fbc_pkg::KEY_W-1:0]  key,
        input logic [fbc_pkg::NEFF_W-1:0] idx
    );
        logic [fbc_pkg::NEFF_W:0]    twice;
        logic [fbc_pkg::ROT_W-1:0]   amt;
        logic [2*fbc_pkg::KEY_W-1:0] dbl;
        twice = {idx, 1'b0};
        amt   = fbc_pkg::ROT_W'(twice % fbc_pkg::KEY_ROTATE_MOD);
        dbl   = {key, key} << amt;
        // rotate left: upper copy holds the rotated key
        return dbl[fbc_pkg::KEY_W +: fbc_pkg::HALF_W];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= fbc_pkg::RCNT_W'(16);
            dir_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fbc_pkg::REG_KEY:    key_reg    <= cfg_data;
                fbc_pkg::REG_ROUNDS: rounds_reg <= cfg_data[fbc_pkg::RCNT_W-1:0];
                fbc_pkg::REG_DIR:    dir_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // saturate round count to the row length
    always_comb
    begin
        if (fbc_pkg::NEFF_W'(rounds_reg) > fbc_pkg::NEFF_W'(N))
        begin
            n_eff = fbc_pkg::NEFF_W'(N);
        end
        else
        begin
            n_eff = fbc_pkg::NEFF_W'(rounds_reg);
        end
    end

    assign byte_key = key_reg[7:0] ^ key_reg[15:8] ^ key_reg[23:16] ^
                      fbc_pkg::BYTE_W'(n_eff);

    // word entry: mask byte pairs, finish lone bytes here
    always_comb
    begin
        item_c[0] = '0;
        case (req_data.command)
            fbc_pkg::CMD_BLOCK:
            begin
                item_c[0].active = 1'b1;
                item_c[0].left   = req_data.left_half;
                item_c[0].right  = req_data.right_half;
            end
            fbc_pkg::CMD_PAIR:
            begin
                item_c[0].active = 1'b1;
                item_c[0].pair   = 1'b1;
                item_c[0].left   = {24'b0, req_data.left_half[7:0]};
                item_c[0].right  = {24'b0, req_data.right_half[7:0]};
            end
            fbc_pkg::CMD_BYTE:
            begin
                item_c[0].left = {24'b0, req_data.left_half[7:0] ^ byte_key};
            end
            default:
            begin
                item_c[0] = '0;
            end
        endcase
    end

    assign valid_c[0] = req_valid;
    assign req_stall  = hold_c[0];
    assign hold_c[N]  = rsp_stall;

    for (genvar j = 0; j < N; j++)
    begin : g_cell
        localparam logic [fbc_pkg::NEFF_W-1:0] POS = fbc_pkg::NEFF_W'(j);
        logic [fbc_pkg::NEFF_W-1:0] idx;

        // decrypt walks the rounds from the top down
        assign idx = dir_reg ? (n_eff - POS - fbc_pkg::NEFF_W'(1)) : POS;

        always_comb
        begin
            ctl_c[j].live    = POS < n_eff;
            ctl_c[j].decrypt = dir_reg;
            ctl_c[j].rkey    = round_key(key_reg, idx);
        end

        fbc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl_c[j]),
            .up_valid (valid_c[j]),
            .up_item  (item_c[j]),
            .up_hold  (hold_c[j]),
            .dn_valid (valid_c[j+1]),
            .dn_item  (item_c[j+1]),
            .dn_hold  (hold_c[j+1])
        );
    end

    assign rsp_valid          = valid_c[N];
    assign rsp_data.out_left  = item_c[N].left;
    assign rsp_data.out_right = item_c[N].right;

endmodule

[rtl/fbc_checker.sv]
// fbc_checker: port-level checks of the feistel block cipher, bound to the top level
// depends on fbc_pkg and feistel_block_cipher_top

module fbc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input fbc_pkg::rsp_t rsp_data
);

    localparam int CNT_W = $clog2(fbc_pkg::MAX_ROUNDS + 2);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             take_in;
    logic             take_out;

    assign take_in  = req_valid && !req_stall;
    assign take_out = rsp_valid && !rsp_stall;

    always_comb
    begin
        count_next = count_reg;
        if (take_in && !take_out)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (take_out && !take_in)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled rsp word changed or dropped");

    // no result without a word in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count_reg != '0)
        else $error("rsp word with nothing in flight");

    // the row never holds more words than it has cells
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(fbc_pkg::MAX_ROUNDS))
        else $error("more words in flight than cells");

    // input backs up only when the row is full and the output is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall &&
                      count_reg == CNT_W'(fbc_pkg::MAX_ROUNDS))
        else $error("req stalled with room in the row");

endmodule

bind feistel_block_cipher_top fbc_checker u_fbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
